[hdl/pptbp_pkg.sv]
// Shared types and constants of the per-port token bucket policer.
// Depends on nothing; every other file of the block imports it.
package pptbp_pkg;

   localparam int DEF_FLOWS  = 64;
   localparam int SLOT_MAX_W = 10;

   localparam int PORT_W = 16;
   localparam int TIME_W = 64;
   localparam int TOK_W  = 20;
   localparam int SEC_W  = 35;
   localparam int PROD_W = TOK_W + SEC_W;
   localparam int SUM_W  = PROD_W + 1;

   // One second is 2^9 * 5^9 ns. SEC_RECIP is ceil(2^76 / 5^9), which gives exact
   // quotients for every 55-bit operand.
   localparam int NS_SHIFT  = 9;
   localparam int LIMB_W    = 28;
   localparam int RCP_W     = 2 * LIMB_W;
   localparam int RCP_SHIFT = 76;
   localparam int ACC_W     = 2 * LIMB_W + 1;
   localparam logic [RCP_W-1:0] SEC_RECIP = 56'd38685626227668134;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 20;

   localparam logic [TOK_W-1:0] RATE_RESET  = 20'd8;
   localparam logic [TOK_W-1:0] DEPTH_RESET = 20'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REFILL_RATE  = 8'd0,
      CSR_BUCKET_DEPTH = 8'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_HIT,
      KIND_NEW,
      KIND_FULL
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [SLOT_MAX_W-1:0]   slot;
      logic [TIME_W-1:0]       now_ns;
   } item_type;

   typedef enum logic [1:0] {
      FRONT_CLEAR,
      FRONT_IDLE,
      FRONT_LOOKUP
   } front_state_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_READ,
      BACK_DIV,
      BACK_MUL,
      BACK_SUM
   } back_state_type;

   typedef enum logic [2:0] {
      DIV_IDLE,
      DIV_MUL_LL,
      DIV_MUL_HL,
      DIV_MUL_LH,
      DIV_MUL_HH,
      DIV_ACC_HH,
      DIV_DONE
   } div_state_type;

endpackage

[hdl/pptbp_fifo.sv]
// Short item queue between the classifying front end and the token back end.
// Depends on pptbp_pkg for the item type and the queue depth.
module pptbp_fifo import pptbp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   item_type             mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff;
   logic [Q_PTR_W-1:0]   rd_ptr_ff;
   logic [Q_PTR_W:0]     cnt_ff;
   logic [Q_PTR_W:0]     cnt_in;
   logic                 push_ok;
   logic                 pop_ok;

   assign full     = (cnt_ff == (Q_PTR_W + 1)'(Q_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push_ok) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[hdl/pptbp_front.sv]
// Front end: accepts items, looks the port up in the port-to-slot map and allocates new slots.
// Depends on pptbp_pkg; feeds classified items into pptbp_fifo.
module pptbp_front import pptbp_pkg::*; #(
   parameter int FLOWS = DEF_FLOWS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [PORT_W-1:0] req_dest_port,
   input  logic [TIME_W-1:0] req_now_ns,
   output logic              q_push,
   output item_type          q_item,
   input  logic              q_full
);

   localparam int SLOT_W    = (FLOWS > 1) ? $clog2(FLOWS) : 1;
   localparam int CNT_W     = $clog2(FLOWS + 1);
   localparam int MAP_DEPTH = 1 << PORT_W;
   localparam int MAP_W     = SLOT_W + 1;

   logic [MAP_W-1:0]  map_mem [MAP_DEPTH];
   logic [MAP_W-1:0]  map_rd_ff;
   front_state_type   state_ff;
   front_state_type   state_in;
   logic [PORT_W-1:0] clr_addr_ff;
   logic [PORT_W-1:0] clr_addr_in;
   logic [CNT_W-1:0]  fill_ff;
   logic [CNT_W-1:0]  fill_in;
   logic [PORT_W-1:0] port_ff;
   logic [TIME_W-1:0] now_ff;
   logic              map_we;
   logic [PORT_W-1:0] map_waddr;
   logic [MAP_W-1:0]  map_wdata;
   logic              accept;
   logic              hit;
   logic              room;
   logic [SLOT_W-1:0] slot_sel;

   assign hit      = map_rd_ff[SLOT_W];
   assign room     = (fill_ff < CNT_W'(FLOWS));
   assign slot_sel = hit ? map_rd_ff[SLOT_W-1:0] : fill_ff[SLOT_W-1:0];

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      fill_in       = fill_ff;
      map_we        = 1'b0;
      map_waddr     = port_ff;
      map_wdata     = {1'b1, fill_ff[SLOT_W-1:0]};
      q_push        = 1'b0;
      req_full      = 1'b1;
      accept        = 1'b0;
      q_item.now_ns = now_ff;
      q_item.slot   = SLOT_MAX_W'(slot_sel);
      if (hit) begin
         q_item.kind = KIND_HIT;
      end else if (room) begin
         q_item.kind = KIND_NEW;
      end else begin
         q_item.kind = KIND_FULL;
      end
      unique case (state_ff)
         FRONT_CLEAR: begin
            map_we      = 1'b1;
            map_waddr   = clr_addr_ff;
            map_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = FRONT_IDLE;
            end
         end
         FRONT_IDLE: begin
            req_full = 1'b0;
            accept   = req_push;
            if (req_push) begin
               state_in = FRONT_LOOKUP;
            end
         end
         FRONT_LOOKUP: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = FRONT_IDLE;
               if (!hit && room) begin
                  map_we  = 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = FRONT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FRONT_CLEAR;
         clr_addr_ff <= '0;
         fill_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         fill_ff     <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         port_ff <= req_dest_port;
         now_ff  <= req_now_ns;
      end
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      if (accept) begin
         map_rd_ff <= map_mem[req_dest_port];
      end
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(FLOWS))
      else $error("slot fill count passed the table size");
`endif

endmodule

[hdl/pptbp_sec_div.sv]
// Seconds unit: turns elapsed nanoseconds into whole seconds by a multiply with a fixed
// reciprocal, one 28-by-28 partial product a cycle. Depends on pptbp_pkg.
module pptbp_sec_div import pptbp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TIME_W-1:0] dividend,
   output logic              done,
   output logic [SEC_W-1:0]  quotient
);

   localparam int Y_W = TIME_W - NS_SHIFT;

   div_state_type       state_ff;
   div_state_type       state_in;
   logic [Y_W-1:0]      y_ff;
   logic [RCP_W-1:0]    mul_ff;
   logic [RCP_W-1:0]    mul_in;
   logic [ACC_W-1:0]    acc_ff;
   logic [ACC_W-1:0]    acc_in;
   logic [LIMB_W-1:0]   mul_a;
   logic [LIMB_W-1:0]   mul_b;
   logic [LIMB_W-1:0]   y_lo;
   logic [LIMB_W-1:0]   y_hi;
   logic [LIMB_W-1:0]   m_lo;
   logic [LIMB_W-1:0]   m_hi;

   assign y_lo     = y_ff[LIMB_W-1:0];
   assign y_hi     = LIMB_W'(y_ff[Y_W-1:LIMB_W]);
   assign m_lo     = SEC_RECIP[LIMB_W-1:0];
   assign m_hi     = SEC_RECIP[RCP_W-1:LIMB_W];
   assign mul_in   = mul_a * mul_b;
   assign done     = (state_ff == DIV_DONE);
   assign quotient = acc_ff[RCP_SHIFT-2*LIMB_W +: SEC_W];

   always_comb begin
      state_in = state_ff;
      mul_a    = y_lo;
      mul_b    = m_lo;
      acc_in   = acc_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               state_in = DIV_MUL_LL;
            end
         end
         DIV_MUL_LL: begin
            state_in = DIV_MUL_HL;
         end
         DIV_MUL_HL: begin
            mul_a    = y_hi;
            acc_in   = ACC_W'(mul_ff);
            state_in = DIV_MUL_LH;
         end
         DIV_MUL_LH: begin
            mul_b    = m_hi;
            acc_in   = (acc_ff >> LIMB_W) + ACC_W'(mul_ff);
            state_in = DIV_MUL_HH;
         end
         DIV_MUL_HH: begin
            mul_a    = y_hi;
            mul_b    = m_hi;
            acc_in   = acc_ff + ACC_W'(mul_ff);
            state_in = DIV_ACC_HH;
         end
         DIV_ACC_HH: begin
            acc_in   = (acc_ff >> LIMB_W) + ACC_W'(mul_ff);
            state_in = DIV_DONE;
         end
         DIV_DONE: begin
            state_in = DIV_IDLE;
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         y_ff <= dividend[TIME_W-1:NS_SHIFT];
      end
      mul_ff <= mul_in;
      acc_ff <= acc_in;
   end

`ifndef SYNTHESIS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == DIV_IDLE))
      else $error("seconds unit started while a conversion was still running");
   a_quotient_fits: assert property (@(posedge clock) disable iff (reset)
      done |-> (acc_ff[ACC_W-1:RCP_SHIFT-2*LIMB_W+SEC_W] == '0))
      else $error("seconds unit finished with a quotient wider than its port");
`endif

endmodule

[hdl/pptbp_back.sv]
// Back end: holds the configuration, the per-slot token and time stores, refills and charges buckets.
// Depends on pptbp_pkg and pptbp_sec_div; takes items from pptbp_fifo and drives the result register.
module pptbp_back import pptbp_pkg::*; #(
   parameter int FLOWS = DEF_FLOWS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  q_empty,
   input  item_type              q_item,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic                  rsp_verdict,
   output logic                  rsp_new_flow,
   output logic                  rsp_table_full,
   output logic [TOK_W-1:0]      rsp_tokens_left
);

   localparam int SLOT_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;

   logic [TOK_W-1:0]  rate_ff;
   logic [TOK_W-1:0]  depth_ff;
   back_state_type    state_ff;
   back_state_type    state_in;
   item_type          item_ff;
   logic [TOK_W-1:0]  tok_mem [FLOWS];
   logic [TIME_W-1:0] time_mem [FLOWS];
   logic [TOK_W-1:0]  tok_rd_ff;
   logic [TIME_W-1:0] time_rd_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              out_valid_ff;
   logic              verdict_ff;
   logic              new_flow_ff;
   logic              table_full_ff;
   logic [TOK_W-1:0]  tokens_ff;

   logic              take;
   logic              div_start;
   logic              div_done;
   logic [SEC_W-1:0]  seconds;
   logic              mem_we;
   logic              time_we;
   logic [SLOT_W-1:0] mem_waddr;
   logic [TOK_W-1:0]  tok_wdata;
   logic [TIME_W-1:0] time_wdata;
   logic              out_load;
   logic              out_free;
   logic              res_verdict;
   logic              res_new_flow;
   logic              res_table_full;
   logic [TOK_W-1:0]  res_tokens;
   logic [TOK_W-1:0]  start_tokens;
   logic [SUM_W-1:0]  sum;
   logic [TOK_W-1:0]  clipped;
   logic              pass;
   logic [TOK_W-1:0]  tok_after;

   assign rsp_empty       = !out_valid_ff;
   assign rsp_verdict     = verdict_ff;
   assign rsp_new_flow    = new_flow_ff;
   assign rsp_table_full  = table_full_ff;
   assign rsp_tokens_left = tokens_ff;

   assign out_free     = !out_valid_ff || rsp_pop;
   assign start_tokens = (depth_ff == '0) ? '0 : depth_ff - 1'b1;
   assign sum          = {1'b0, prod_ff} + SUM_W'(tok_rd_ff);
   assign clipped      = (sum > SUM_W'(depth_ff)) ? depth_ff : sum[TOK_W-1:0];
   assign pass         = (clipped != '0);
   assign tok_after    = pass ? clipped - 1'b1 : '0;

   pptbp_sec_div u_sec_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (item_ff.now_ns - time_rd_ff),
      .done     (div_done),
      .quotient (seconds)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= RATE_RESET;
         depth_ff <= DEPTH_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_REFILL_RATE:  rate_ff  <= csr_wdata[TOK_W-1:0];
            CSR_BUCKET_DEPTH: depth_ff <= csr_wdata[TOK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      q_pop          = 1'b0;
      take           = 1'b0;
      div_start      = 1'b0;
      mem_we         = 1'b0;
      time_we        = 1'b0;
      mem_waddr      = item_ff.slot[SLOT_W-1:0];
      tok_wdata      = tok_after;
      time_wdata     = item_ff.now_ns;
      out_load       = 1'b0;
      res_verdict    = pass;
      res_new_flow   = 1'b0;
      res_table_full = 1'b0;
      res_tokens     = tok_after;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!q_empty) begin
               priority case (q_item.kind)
                  KIND_HIT: begin
                     q_pop    = 1'b1;
                     take     = 1'b1;
                     state_in = BACK_READ;
                  end
                  KIND_NEW: begin
                     if (out_free) begin
                        q_pop          = 1'b1;
                        mem_we         = 1'b1;
                        time_we        = 1'b1;
                        mem_waddr      = q_item.slot[SLOT_W-1:0];
                        tok_wdata      = start_tokens;
                        time_wdata     = q_item.now_ns;
                        out_load       = 1'b1;
                        res_verdict    = 1'b1;
                        res_new_flow   = 1'b1;
                        res_tokens     = start_tokens;
                     end
                  end
                  default: begin
                     if (out_free) begin
                        q_pop          = 1'b1;
                        out_load       = 1'b1;
                        res_verdict    = 1'b1;
                        res_new_flow   = 1'b1;
                        res_table_full = 1'b1;
                        res_tokens     = '0;
                     end
                  end
               endcase
            end
         end
         BACK_READ: begin
            div_start = 1'b1;
            state_in  = BACK_DIV;
         end
         BACK_DIV: begin
            if (div_done) begin
               state_in = BACK_MUL;
            end
         end
         BACK_MUL: begin
            state_in = BACK_SUM;
         end
         BACK_SUM: begin
            if (out_free) begin
               mem_we   = 1'b1;
               time_we  = pass;
               out_load = 1'b1;
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= q_item;
      end
      if (state_ff == BACK_MUL) begin
         prod_ff <= seconds * rate_ff;
      end
      if (out_load) begin
         verdict_ff    <= res_verdict;
         new_flow_ff   <= res_new_flow;
         table_full_ff <= res_table_full;
         tokens_ff     <= res_tokens;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tok_mem[mem_waddr] <= tok_wdata;
         if (time_we) begin
            time_mem[mem_waddr] <= time_wdata;
         end
      end
      if (take) begin
         tok_rd_ff  <= tok_mem[q_item.slot[SLOT_W-1:0]];
         time_rd_ff <= time_mem[q_item.slot[SLOT_W-1:0]];
      end
   end

`ifndef SYNTHESIS
   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_table_full) |->
         (rsp_new_flow && rsp_verdict && (rsp_tokens_left == '0)))
      else $error("table-full item without new flow, transmit and zero tokens");
   a_drop_known: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_verdict) |-> !rsp_new_flow)
      else $error("a new flow item was dropped");
`endif

endmodule

[hdl/per_port_token_bucket_policer_unit.sv]
// Top level of the per-port token bucket policer.
// Depends on pptbp_pkg, pptbp_fifo, pptbp_front and pptbp_back.
//
// Each item carries a destination port and a nanosecond timestamp and yields one result:
// transmit or drop, whether the port was new, whether the flow table was full, and the
// tokens left. After reset the block clears its port-to-slot map and holds req_full
// high meanwhile. The front end takes an item, reads the map, then classifies the item
// and pushes it into a 4-item queue once the queue has room; it takes no new item until
// then. The back end finishes a new flow or a table-full item straight from its idle
// state; a known flow goes through a memory read, the seconds unit that multiplies the
// elapsed time by a fixed reciprocal of one second, one partial product a cycle, then a
// multiply and the refill-and-charge step. Configuration writes take effect at once.
module per_port_token_bucket_policer_unit import pptbp_pkg::*; #(
   parameter int FLOWS = DEF_FLOWS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [PORT_W-1:0]     req_dest_port,
   input  logic [TIME_W-1:0]     req_now_ns,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic                  rsp_verdict,
   output logic                  rsp_new_flow,
   output logic                  rsp_table_full,
   output logic [TOK_W-1:0]      rsp_tokens_left,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_empty;
   item_type q_in_item;
   item_type q_out_item;

   pptbp_front #(
      .FLOWS (FLOWS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_dest_port (req_dest_port),
      .req_now_ns    (req_now_ns),
      .q_push        (q_push),
      .q_item        (q_in_item),
      .q_full        (q_full)
   );

   pptbp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_out_item),
      .empty     (q_empty)
   );

   pptbp_back #(
      .FLOWS (FLOWS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .q_empty         (q_empty),
      .q_item          (q_out_item),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_verdict     (rsp_verdict),
      .rsp_new_flow    (rsp_new_flow),
      .rsp_table_full  (rsp_table_full),
      .rsp_tokens_left (rsp_tokens_left)
   );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of per_port_token_bucket_policer_unit: directed and random items,
// checked against a behavioral flow table. Depends on pptbp_pkg and the block's RTL.
module tb;
   import pptbp_pkg::*;

   localparam int FLOWS = DEF_FLOWS;
   localparam int MAX_CYCLES = 1000000;
   localparam int MAX_REPORTS = 10;
   localparam logic [TIME_W-1:0] NS_SECOND = 64'd1000000000;
   localparam logic [TOK_W-1:0] TOK_MAX = '1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_INDEX = 8'hFF;

   typedef struct {
      logic             verdict;
      logic             new_flow;
      logic             table_full;
      logic [TOK_W-1:0] tokens_left;
   } verdict_type;

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   logic [PORT_W-1:0]     req_dest_port;
   logic [TIME_W-1:0]     req_now_ns;
   logic                  rsp_empty;
   logic                  rsp_pop;
   logic                  rsp_verdict;
   logic                  rsp_new_flow;
   logic                  rsp_table_full;
   logic [TOK_W-1:0]      rsp_tokens_left;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bit                flow_valid[FLOWS];
   logic [PORT_W-1:0] flow_port[FLOWS];
   logic [TOK_W-1:0]  flow_tokens[FLOWS];
   logic [TIME_W-1:0] flow_stamp[FLOWS];
   logic [TOK_W-1:0]  rate_reg = RATE_RESET;
   logic [TOK_W-1:0]  depth_reg = DEPTH_RESET;

   verdict_type       pending_verdicts[$];
   logic [PORT_W-1:0] port_pool[FLOWS];
   logic [TIME_W-1:0] wall_ns = '0;
   int                error_count = 0;
   int                cycle_count = 0;
   int                hold_left = 0;
   bit                idle_on = 1'b1;

   per_port_token_bucket_policer_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_dest_port   (req_dest_port),
      .req_now_ns      (req_now_ns),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_verdict     (rsp_verdict),
      .rsp_new_flow    (rsp_new_flow),
      .rsp_table_full  (rsp_table_full),
      .rsp_tokens_left (rsp_tokens_left),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic verdict_type police_packet(input logic [PORT_W-1:0] dest_port,
                                                 input logic [TIME_W-1:0] stamp_ns);
      verdict_type res;
      int hit;
      int free_slot;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] count;
      hit = -1;
      free_slot = -1;
      for (int i = 0; i < FLOWS; i++) begin
         if (flow_valid[i]) begin
            if (hit < 0 && flow_port[i] == dest_port) hit = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      res.verdict = 1'b1;
      res.new_flow = 1'b1;
      res.table_full = 1'b0;
      res.tokens_left = '0;
      if (hit >= 0) begin
         elapsed = stamp_ns - flow_stamp[hit];
         count = TIME_W'(flow_tokens[hit]) + (elapsed / NS_SECOND) * TIME_W'(rate_reg);
         if (count > TIME_W'(depth_reg)) count = TIME_W'(depth_reg);
         res.new_flow = 1'b0;
         res.verdict = (count != 0);
         if (count != 0) begin
            count = count - 1;
            flow_stamp[hit] = stamp_ns;
         end
         flow_tokens[hit] = count[TOK_W-1:0];
         res.tokens_left = count[TOK_W-1:0];
      end else if (free_slot < 0) begin
         res.table_full = 1'b1;
      end else begin
         flow_valid[free_slot] = 1'b1;
         flow_port[free_slot] = dest_port;
         flow_tokens[free_slot] = (depth_reg == 0) ? '0 : depth_reg - 1'b1;
         flow_stamp[free_slot] = stamp_ns;
         res.tokens_left = flow_tokens[free_slot];
      end
      return res;
   endfunction

   function automatic logic [PORT_W-1:0] pick_port();
      if ($urandom_range(0, 99) < 85) return port_pool[$urandom_range(0, FLOWS - 1)];
      return PORT_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [TIME_W-1:0] pick_time();
      case ($urandom_range(0, 19))
         0: begin
            wall_ns = {$urandom, $urandom};
         end
         1: begin
            wall_ns = wall_ns + $urandom_range(0, 3) * NS_SECOND
                      + $urandom_range(0, 999999999);
         end
         2: begin
            wall_ns = wall_ns - $urandom_range(0, 1000000);
         end
         default: begin
            wall_ns = wall_ns + $urandom_range(0, 20000000);
         end
      endcase
      return wall_ns;
   endfunction

   task automatic send_packet(input logic [PORT_W-1:0] dest_port,
                              input logic [TIME_W-1:0] stamp_ns);
      req_push <= 1'b1;
      req_dest_port <= dest_port;
      req_now_ns <= stamp_ns;
      do @(posedge clock); while (req_full);
      pending_verdicts.push_back(police_packet(dest_port, stamp_ns));
   endtask

   task automatic pause_sender(input int cycles);
      req_push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      if (index == CSR_REFILL_RATE) rate_reg = value;
      else if (index == CSR_BUCKET_DEPTH) depth_reg = value;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_result();
      verdict_type want;
      if (pending_verdicts.size() == 0) begin
         error_count++;
         if (error_count <= MAX_REPORTS) begin
            $display("unexpected result item: verdict=%0b new_flow=%0b",
                     rsp_verdict, rsp_new_flow);
            $display("          table_full=%0b tokens_left=%0d",
                     rsp_table_full, rsp_tokens_left);
         end
      end else begin
         want = pending_verdicts.pop_front();
         if (rsp_verdict !== want.verdict || rsp_new_flow !== want.new_flow ||
             rsp_table_full !== want.table_full || rsp_tokens_left !== want.tokens_left) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("mismatch: expected verdict=%0b new_flow=%0b table_full=%0b %s%0d",
                        want.verdict, want.new_flow, want.table_full, "tokens_left=",
                        want.tokens_left);
               $display("          actual   verdict=%0b new_flow=%0b table_full=%0b %s%0d",
                        rsp_verdict, rsp_new_flow, rsp_table_full, "tokens_left=",
                        rsp_tokens_left);
            end
         end
      end
   endtask

   initial begin : result_monitor
      int stall_left;
      stall_left = 0;
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) check_result();
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      while (cycle_count < MAX_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   task automatic test_flow_refill();
      write_register(CSR_REFILL_RATE, 20'd8);
      write_register(CSR_BUCKET_DEPTH, 20'd16);
      send_packet(port_pool[0], 64'd0);
      send_packet(port_pool[0], 64'd999999999);
      send_packet(port_pool[0], 64'd1999999998);
      send_packet(port_pool[0], 64'd2999999998);
      // The timestamp wraps past 2^64 between these two items.
      send_packet(port_pool[1], 64'hFFFF_FFFF_FFFF_FFFF);
      send_packet(port_pool[1], 64'd1999999999);
      send_packet(port_pool[1], 64'd1999999999);
   endtask

   task automatic test_bucket_limits();
      wait_drained();
      write_register(CSR_BUCKET_DEPTH, 20'd1);
      send_packet(port_pool[2], 64'd10000000000);
      send_packet(port_pool[2], 64'd10000000000);
      send_packet(port_pool[2], 64'd10600000000);
      send_packet(port_pool[2], 64'd11000000000);
      send_packet(port_pool[0], 64'd2999999998);
      wait_drained();
      write_register(CSR_REFILL_RATE, 20'd0);
      write_register(CSR_BUCKET_DEPTH, 20'd16);
      send_packet(port_pool[0], 64'hFFFF_FFFF_FFFF_FFFF);
      wait_drained();
      write_register(CSR_REFILL_RATE, TOK_MAX);
      write_register(CSR_BUCKET_DEPTH, 20'd0);
      send_packet(port_pool[3], 64'd20000000000);
      send_packet(port_pool[3], 64'd25000000000);
      send_packet(port_pool[1], 64'd30000000000);
      wait_drained();
      write_register(CSR_BUCKET_DEPTH, TOK_MAX);
      send_packet(port_pool[1], 64'hFFFF_FFFF_FFFF_FFFF);
      send_packet(port_pool[4], 64'hFFFF_FFFF_FFFF_FFFF);
      wait_drained();
      write_register(CSR_SPARE_INDEX, 20'd5);
      write_register(CSR_LAST_INDEX, 20'd0);
      send_packet(port_pool[4], 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   task automatic test_table_full();
      logic [PORT_W-1:0] fresh;
      bit known;
      wait_drained();
      write_register(CSR_REFILL_RATE, 20'd8);
      write_register(CSR_BUCKET_DEPTH, 20'd16);
      for (int i = 0; i < FLOWS; i++) send_packet(port_pool[i], pick_time());
      for (int k = 0; k < 4; k++) begin
         do begin
            fresh = PORT_W'($urandom_range(0, 65535));
            known = 1'b0;
            for (int j = 0; j < FLOWS; j++) if (port_pool[j] == fresh) known = 1'b1;
         end while (known);
         send_packet(fresh, pick_time());
      end
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_left = 300;
      for (int i = 0; i < 30; i++) send_packet(pick_port(), pick_time());
      wait_drained();
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 6; phase++) begin
         wait_drained();
         case (phase)
            0: begin
               write_register(CSR_REFILL_RATE, 20'd8);
               write_register(CSR_BUCKET_DEPTH, 20'd16);
            end
            1: begin
               write_register(CSR_REFILL_RATE, 20'd0);
               write_register(CSR_BUCKET_DEPTH, 20'd1);
            end
            2: begin
               write_register(CSR_REFILL_RATE, TOK_MAX);
               write_register(CSR_BUCKET_DEPTH, TOK_MAX);
            end
            3: begin
               write_register(CSR_REFILL_RATE, 20'd1);
               write_register(CSR_BUCKET_DEPTH, 20'd0);
            end
            4: begin
               write_register(CSR_REFILL_RATE, CSR_DATA_W'($urandom));
               write_register(CSR_BUCKET_DEPTH, CSR_DATA_W'($urandom_range(1, 64)));
            end
            default: begin
               write_register(CSR_REFILL_RATE, CSR_DATA_W'($urandom));
               write_register(CSR_BUCKET_DEPTH, CSR_DATA_W'($urandom));
            end
         endcase
         for (int i = 0; i < 250; i++) begin
            send_packet(pick_port(), pick_time());
            if (idle_on && $urandom_range(0, 9) == 0) pause_sender($urandom_range(1, 18));
         end
      end
   endtask

   task automatic test_steady_stream();
      wait_drained();
      idle_on = 1'b0;
      write_register(CSR_REFILL_RATE, CSR_DATA_W'($urandom_range(1, 4)));
      write_register(CSR_BUCKET_DEPTH, CSR_DATA_W'($urandom_range(2, 32)));
      for (int i = 0; i < 250; i++) send_packet(pick_port(), pick_time());
   endtask

   initial begin
      logic [PORT_W-1:0] candidate;
      bit dup;
      reset <= 1'b1;
      req_push <= 1'b0;
      req_dest_port <= '0;
      req_now_ns <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      port_pool[0] = '0;
      port_pool[1] = '1;
      for (int i = 2; i < FLOWS; i++) begin
         do begin
            candidate = PORT_W'($urandom_range(1, 65534));
            dup = 1'b0;
            for (int j = 0; j < i; j++) if (port_pool[j] == candidate) dup = 1'b1;
         end while (dup);
         port_pool[i] = candidate;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_flow_refill();
      test_bucket_limits();
      test_table_full();
      test_backpressure();
      test_random_settings();
      test_steady_stream();
      wait_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0 && pending_verdicts.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
